FILE: rtl/art_pkg.sv
`default_nettype none

package art_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int MODE_W = 3;
  localparam int METH_W = 2;
  localparam int ADDR_W = 48;
  localparam int SIZE_W = 32;
  localparam int DESC_W = 16;
  localparam int KEY_W  = 32;
  localparam int POS_W  = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT    = 3'd0,
    MODE_REM_POS   = 3'd1,
    MODE_REM_KEY   = 3'd2,
    MODE_REM_SIZE  = 3'd3,
    MODE_REM_ADDR  = 3'd4,
    MODE_FIND_KEY  = 3'd5,
    MODE_FIND_SIZE = 3'd6,
    MODE_FIND_ADDR = 3'd7
  } mode_t;

  // one stored record, packed as a single memory word
  typedef struct packed {
    logic [METH_W-1:0] method;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;
    logic [DESC_W-1:0] descriptor;
    logic [KEY_W-1:0]  key;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // captured command item
  typedef struct packed {
    mode_t             mode;
    rec_t              rec;
    logic [POS_W-1:0]  pos;
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SHIFT
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/allocation_record_table.sv
// Channel   Handshake                Payload
// command   start, busy (in: busy=0) mode, alloc_method, address, block_size,
//                                    descriptor, search_key, position
// result    done (one-cycle strobe)  ok, found_position, found_address,
//                                    found_size, found_key, found_method,
//                                    found_descriptor, record_count
//
// An item is taken when start is high and busy is low; busy then stays high
// until the done strobe. Insert and the trivial remove cases finish straight
// from dispatch. A search scans from position 0 and stops at the first hit;
// a miss scans every held record. A removal then moves the records above the
// hit one slot down; remove at position p starts its read at p. Search and
// compaction are both set by the single read port of the record memory: one
// stored record per cycle.
// Reset: rst (synchronous) empties the table; record memory is not cleared.
// The result side has no back-pressure: done is never held.
`default_nettype none

module allocation_record_table #(
  parameter int MAX_ENTRIES = art_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // command channel
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [art_pkg::MODE_W-1:0]        mode,
  input  wire logic [art_pkg::METH_W-1:0]        alloc_method,
  input  wire logic [art_pkg::ADDR_W-1:0]        address,
  input  wire logic [art_pkg::SIZE_W-1:0]        block_size,
  input  wire logic [art_pkg::DESC_W-1:0]        descriptor,
  input  wire logic signed [art_pkg::KEY_W-1:0]  search_key,
  input  wire logic [art_pkg::POS_W-1:0]         position,
  // result channel
  output logic                                   done,
  output logic                                   ok,
  output logic [art_pkg::POS_W-1:0]              found_position,
  output logic [art_pkg::ADDR_W-1:0]             found_address,
  output logic [art_pkg::SIZE_W-1:0]             found_size,
  output logic signed [art_pkg::KEY_W-1:0]       found_key,
  output logic [art_pkg::METH_W-1:0]             found_method,
  output logic [art_pkg::DESC_W-1:0]             found_descriptor,
  output logic [art_pkg::POS_W-1:0]              record_count
);

  localparam int IW = $clog2(MAX_ENTRIES);

  logic          accept;
  art_pkg::op_t  op;

  logic                      ram_re, ram_we;
  logic [IW-1:0]             ram_raddr, ram_waddr;
  art_pkg::rec_t             ram_wdata;
  logic [art_pkg::REC_W-1:0] ram_rdata_raw;

  logic          res_ok;
  logic [IW-1:0] res_pos, cnt;
  art_pkg::rec_t res_rec;

  // positions are reported in 4 bits whatever the table depth
  logic [IW+3:0] pos_ext, cnt_ext;

  assign accept = start & ~busy;

  // command is held here for the whole operation
  always_ff @(posedge clk) begin
    if (accept) begin
      op.mode           <= art_pkg::mode_t'(mode);
      op.rec.method     <= alloc_method;
      op.rec.address    <= address;
      op.rec.size       <= block_size;
      op.rec.descriptor <= descriptor;
      op.rec.key        <= search_key;
      op.pos            <= position;
    end
  end

  art_ram #(
    .WIDTH (art_pkg::REC_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  art_seq #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .go        (accept),
    .op        (op),
    .busy      (busy),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (art_pkg::rec_t'(ram_rdata_raw)),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .res_vld   (done),
    .res_ok    (res_ok),
    .res_pos   (res_pos),
    .res_rec   (res_rec),
    .cnt       (cnt)
  );

  assign pos_ext = {4'b0000, res_pos};
  assign cnt_ext = {4'b0000, cnt};

  assign ok               = res_ok;
  assign found_position   = pos_ext[3:0];
  assign found_address    = res_rec.address;
  assign found_size       = res_rec.size;
  assign found_key        = res_rec.key;
  assign found_method     = res_rec.method;
  assign found_descriptor = res_rec.descriptor;
  // the count register already holds the post-operation value during done
  assign record_count     = cnt_ext[3:0];

endmodule

`default_nettype wire

FILE: rtl/art_ram.sv
`default_nettype none

module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/art_match.sv
`default_nettype none

module art_match (
  input  wire art_pkg::rec_t rec,
  input  wire art_pkg::op_t  op,
  output logic               hit
);

  // remove-at-position starts reading at the target, so its first word hits
  always_comb begin
    unique case (op.mode)
      art_pkg::MODE_REM_KEY,  art_pkg::MODE_FIND_KEY:  hit = (rec.key == op.rec.key);
      art_pkg::MODE_REM_SIZE, art_pkg::MODE_FIND_SIZE: hit = (rec.size == op.rec.size);
      art_pkg::MODE_REM_ADDR, art_pkg::MODE_FIND_ADDR: hit = (rec.address == op.rec.address);
      art_pkg::MODE_REM_POS:                           hit = 1'b1;
      art_pkg::MODE_INSERT:                            hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/art_seq.sv
`default_nettype none

module art_seq #(
  parameter int MAX_ENTRIES = art_pkg::MAX_ENTRIES_DEF,
  localparam int IW = $clog2(MAX_ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          go,
  input  wire art_pkg::op_t  op,
  output logic               busy,
  output logic               ram_re,
  output logic [IW-1:0]      ram_raddr,
  input  wire art_pkg::rec_t ram_rdata,
  output logic               ram_we,
  output logic [IW-1:0]      ram_waddr,
  output art_pkg::rec_t      ram_wdata,
  output logic               res_vld,
  output logic               res_ok,
  output logic [IW-1:0]      res_pos,
  output art_pkg::rec_t      res_rec,
  output logic [IW-1:0]      cnt
);

  localparam int PW   = IW + 1;
  localparam int CMPW = IW + 4;

  art_pkg::state_t state, state_next;

  logic [PW-1:0] rd_ptr;
  logic          fl_vld;
  logic [IW-1:0] fl_idx;

  logic hit, hit_now, more, full, is_find, pos_lt, pos_eq;

  art_match u_match (
    .rec (ram_rdata),
    .op  (op),
    .hit (hit)
  );

  assign hit_now = fl_vld & hit;
  assign more    = (rd_ptr < PW'(cnt));
  assign full    = (cnt == IW'(MAX_ENTRIES - 1));
  assign pos_lt  = (CMPW'(op.pos) < CMPW'(cnt));
  assign pos_eq  = (CMPW'(op.pos) == CMPW'(cnt));
  assign is_find = (op.mode == art_pkg::MODE_FIND_KEY) ||
                   (op.mode == art_pkg::MODE_FIND_SIZE) ||
                   (op.mode == art_pkg::MODE_FIND_ADDR);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      art_pkg::ST_IDLE: begin
        if (go) state_next = art_pkg::ST_DISPATCH;
      end
      art_pkg::ST_DISPATCH: begin
        if (op.mode == art_pkg::MODE_INSERT) begin
          state_next = art_pkg::ST_IDLE;
        end else if (op.mode == art_pkg::MODE_REM_POS) begin
          state_next = pos_lt ? art_pkg::ST_SCAN : art_pkg::ST_IDLE;
        end else begin
          state_next = art_pkg::ST_SCAN;
        end
      end
      art_pkg::ST_SCAN: begin
        if (hit_now) begin
          state_next = is_find ? art_pkg::ST_IDLE : art_pkg::ST_SHIFT;
        end else if (!more) begin
          state_next = art_pkg::ST_IDLE;
        end
      end
      art_pkg::ST_SHIFT: begin
        if (!more) state_next = art_pkg::ST_IDLE;
      end
    endcase
  end

  // memory controls
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = rd_ptr[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = ram_rdata;
    unique case (state)
      art_pkg::ST_DISPATCH: begin
        if (op.mode == art_pkg::MODE_INSERT && !full) begin
          ram_we    = 1'b1;
          ram_wdata = op.rec;
        end
      end
      art_pkg::ST_SCAN: begin
        ram_re = more;
      end
      art_pkg::ST_SHIFT: begin
        // read j+1 while writing the word read last cycle one slot down
        ram_re    = more;
        ram_we    = fl_vld;
        ram_waddr = fl_idx - IW'(1);
      end
      art_pkg::ST_IDLE: begin
      end
    endcase
  end

  assign busy = (state != art_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= art_pkg::ST_IDLE;
      cnt     <= '0;
      fl_vld  <= 1'b0;
      res_vld <= 1'b0;
      rd_ptr  <= '0;
    end else begin
      state   <= state_next;
      res_vld <= 1'b0;
      fl_vld  <= ram_re;
      fl_idx  <= rd_ptr[IW-1:0];
      if (ram_re) rd_ptr <= rd_ptr + PW'(1);

      unique case (state)
        art_pkg::ST_DISPATCH: begin
          if (op.mode == art_pkg::MODE_INSERT) begin
            res_vld <= 1'b1;
            res_ok  <= !full;
            res_pos <= full ? '0 : cnt;
            res_rec <= '0;
            if (!full) cnt <= cnt + IW'(1);
          end else if (op.mode == art_pkg::MODE_REM_POS) begin
            rd_ptr <= PW'(op.pos);
            if (!pos_lt) begin
              res_vld <= 1'b1;
              res_ok  <= pos_eq;
              res_pos <= pos_eq ? cnt : '0;
              res_rec <= '0;
            end
          end else begin
            rd_ptr <= '0;
          end
        end
        art_pkg::ST_SCAN: begin
          if (hit_now) begin
            res_ok  <= 1'b1;
            res_pos <= fl_idx;
            res_rec <= ram_rdata;
            fl_vld  <= 1'b0;
            if (is_find) begin
              res_vld <= 1'b1;
            end else begin
              rd_ptr <= PW'(fl_idx) + PW'(1);
            end
          end else if (!more) begin
            res_vld <= 1'b1;
            res_ok  <= 1'b0;
            res_pos <= '0;
            res_rec <= '0;
          end
        end
        art_pkg::ST_SHIFT: begin
          if (!more) begin
            res_vld <= 1'b1;
            cnt     <= cnt - IW'(1);
          end
        end
        art_pkg::ST_IDLE: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (rst)
    ram_re && ram_we |-> ram_raddr != ram_waddr)
    else $error("read and write to the same entry in one cycle");

  a_go_when_idle: assert property (@(posedge clk) disable iff (rst)
    go |-> state == art_pkg::ST_IDLE)
    else $error("command taken while busy");

  a_result_ends_work: assert property (@(posedge clk) disable iff (rst)
    res_vld |-> state == art_pkg::ST_IDLE)
    else $error("result strobe while still working");

  a_cnt_moves_with_result: assert property (@(posedge clk) disable iff (rst)
    cnt != $past(cnt) |-> res_vld)
    else $error("record count changed without a result");

  a_shift_below_cnt: assert property (@(posedge clk) disable iff (rst)
    state == art_pkg::ST_SHIFT && ram_we |-> ram_waddr < cnt)
    else $error("compaction write beyond held records");
`endif

endmodule

`default_nettype wire
